/* src/tste_pkg.sv */
// Package for the TIFF strip tag extractor: field widths, tag numbers,
// entry type codes and result status codes. No dependencies.
`default_nettype none

package tste_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned StatusW = 2;
  localparam int unsigned WordW   = 32;
  localparam int unsigned CountW  = 16;

  // Directory entries are twelve bytes long.
  localparam int unsigned EntryBytes = 12;
  localparam int unsigned EntryIdxW  = $clog2(EntryBytes);

  // The first directory may not start inside the eight-byte header.
  localparam logic [WordW-1:0] MinDirOffset = WordW'(8);

  localparam logic [CountW-1:0] TagStripOffset = CountW'(273);
  localparam logic [CountW-1:0] TagStripLength = CountW'(279);

  localparam logic [CountW-1:0] TypeLong  = CountW'(4);
  localparam logic [CountW-1:0] TypeShort = CountW'(3);
  localparam logic [CountW-1:0] TypeAscii = CountW'(2);

  typedef enum logic [StatusW-1:0] {
    ST_OK     = 2'd0,
    ST_TAGS   = 2'd1,
    ST_EARLY  = 2'd2,
    ST_BADOFF = 2'd3
  } status_t;

endpackage : tste_pkg

`default_nettype wire

/* src/tste_if.sv */
// Stream interfaces of the TIFF strip tag extractor: file bytes in, result out.
// Depends on tste_pkg for the field widths.
`default_nettype none

interface tste_byte_if;
  logic                          valid;
  logic                          ready;
  logic [tste_pkg::ByteW-1:0]    data_byte;
  logic                          last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface : tste_byte_if

interface tste_result_if;
  logic                          valid;
  logic                          ready;
  logic [tste_pkg::StatusW-1:0]  status;
  logic [tste_pkg::WordW-1:0]    strip_start;
  logic [tste_pkg::WordW-1:0]    strip_length;

  modport source (output valid, output status, output strip_start, output strip_length,
                  input ready);
  modport sink   (input valid, input status, input strip_start, input strip_length,
                  output ready);
endinterface : tste_result_if

`default_nettype wire

/* src/tiff_strip_tag_extractor.sv */
// Top level of the TIFF strip tag extractor: byte parser and result register.
// Depends on tste_pkg and the stream interfaces in tste_if.sv.
//
// Usage. The feed channel carries the file one byte per beat, in file order,
// with last_byte set on the final byte. The block reads the big-endian first
// directory offset from header bytes 4 to 7, skips forward to it, reads the
// entry count and walks the twelve-byte entries, capturing tags 273 (strip
// offset) and 279 (strip length). At most one result beat is given per file:
// when the directory ends, when the offset is below 8, or on the final byte.
// Throughput is one byte per cycle while feed ready is high: each beat updates
// the parse state, and the result lands in an output register in the cycle after
// the beat that caused it. Feed ready stays high while that register is empty
// or being drained, so bytes keep flowing while a result waits; only when a
// result is held by a stalled receiver does feed ready drop, and then it
// stays low until the result beat is taken. Bytes after the result are
// discarded until the final byte. After the final byte all parse state
// returns to its reset value and the next byte starts a new file.
// Synchronous reset clears the parse state and empties the result register.
`default_nettype none

module tiff_strip_tag_extractor (
  input  wire logic           clk,
  input  wire logic           rst,
  tste_byte_if.sink           feed,
  tste_result_if.source       result
);

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_SKIP,
    PH_COUNT,
    PH_ENTRY,
    PH_DONE
  } phase_t;

  localparam int unsigned ByteW  = tste_pkg::ByteW;
  localparam int unsigned WordW  = tste_pkg::WordW;
  localparam int unsigned CountW = tste_pkg::CountW;
  localparam int unsigned IdxW   = tste_pkg::EntryIdxW;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(tste_pkg::EntryBytes - 1);

  // Parse state.
  phase_t              phase, phase_next;
  logic [WordW-1:0]    byte_position, byte_position_next;
  logic [WordW-1:0]    directory_offset, directory_offset_next;
  logic [CountW-1:0]   entries_left, entries_left_next;
  logic [IdxW-1:0]     entry_byte_index, entry_byte_index_next;
  logic [WordW-1:0]    offset_seen, offset_seen_next;
  logic [WordW-1:0]    length_seen, length_seen_next;
  logic [1:0]          match_count, match_count_next;
  logic [ByteW-1:0]    entry_bytes [tste_pkg::EntryBytes];

  // Result register.
  logic                     out_valid;
  tste_pkg::status_t        out_status;
  logic [WordW-1:0]         out_offset;
  logic [WordW-1:0]         out_length;

  logic                take;
  logic                emit;
  tste_pkg::status_t   emit_status;
  logic [ByteW-1:0]    b;
  logic [CountW-1:0]   entry_tag;
  logic [CountW-1:0]   entry_type;
  logic [WordW-1:0]    entry_value;
  logic                tag_is_offset;
  logic                tag_is_length;

  assign feed.ready          = !out_valid || result.ready;
  assign take                = feed.valid && feed.ready;
  assign b                   = feed.data_byte;

  assign result.valid        = out_valid;
  assign result.status       = out_status;
  assign result.strip_start  = out_offset;
  assign result.strip_length = out_length;

  // Entry decode. It is used only on the twelfth entry byte, which is still
  // on the feed port, so byte 11 comes from there rather than the store.
  assign entry_tag  = {entry_bytes[0], entry_bytes[1]};
  assign entry_type = {entry_bytes[2], entry_bytes[3]};

  always_comb begin
    priority if (entry_type == tste_pkg::TypeLong) begin
      entry_value = {entry_bytes[8], entry_bytes[9], entry_bytes[10], b};
    end else if (entry_type == tste_pkg::TypeShort) begin
      entry_value = {16'h0000, entry_bytes[8], entry_bytes[9]};
    end else if (entry_type == tste_pkg::TypeAscii) begin
      entry_value = {24'h000000, entry_bytes[8]};
    end else begin
      entry_value = {b, entry_bytes[10], entry_bytes[9], entry_bytes[8]};
    end
  end

  assign tag_is_offset = (entry_tag == tste_pkg::TagStripOffset);
  assign tag_is_length = (entry_tag == tste_pkg::TagStripLength);

  // Next-state logic for one accepted byte.
  always_comb begin
    phase_next            = phase;
    byte_position_next    = byte_position + WordW'(1);
    directory_offset_next = directory_offset;
    entries_left_next     = entries_left;
    entry_byte_index_next = entry_byte_index;
    offset_seen_next      = offset_seen;
    length_seen_next      = length_seen;
    match_count_next      = match_count;
    emit                  = 1'b0;
    emit_status           = tste_pkg::ST_OK;

    unique case (phase)
      PH_HEADER: begin
        if (byte_position >= WordW'(4)) begin
          directory_offset_next = {directory_offset[WordW-ByteW-1:0], b};
        end
        if (byte_position == WordW'(7)) begin
          priority if (directory_offset_next < tste_pkg::MinDirOffset) begin
            emit        = 1'b1;
            emit_status = tste_pkg::ST_BADOFF;
          end else if (directory_offset_next == tste_pkg::MinDirOffset) begin
            phase_next            = PH_COUNT;
            entry_byte_index_next = '0;
          end else begin
            phase_next = PH_SKIP;
          end
        end
      end
      PH_SKIP: begin
        if (byte_position_next == directory_offset) begin
          phase_next            = PH_COUNT;
          entry_byte_index_next = '0;
        end
      end
      PH_COUNT: begin
        if (entry_byte_index == '0) begin
          entries_left_next     = {b, 8'h00};
          entry_byte_index_next = IdxW'(1);
        end else begin
          entries_left_next     = {entries_left[CountW-1:ByteW], b};
          entry_byte_index_next = '0;
          if (entries_left_next == '0) begin
            emit = 1'b1;
          end else begin
            phase_next = PH_ENTRY;
          end
        end
      end
      PH_ENTRY: begin
        if (entry_byte_index == LastIdx) begin
          entry_byte_index_next = '0;
          if (tag_is_offset) begin
            offset_seen_next = entry_value;
          end
          if (tag_is_length) begin
            length_seen_next = entry_value;
          end
          if ((tag_is_offset || tag_is_length) && match_count != 2'd3) begin
            match_count_next = match_count + 2'd1;
          end
          entries_left_next = entries_left - CountW'(1);
          if (entries_left_next == '0) begin
            emit = 1'b1;
          end
        end else begin
          entry_byte_index_next = entry_byte_index + IdxW'(1);
        end
      end
      PH_DONE: begin
      end
      default: begin
      end
    endcase

    // A directory result reports ok only with exactly two tag matches.
    if (emit && phase != PH_HEADER) begin
      emit_status = (match_count_next == 2'd2) ? tste_pkg::ST_OK : tste_pkg::ST_TAGS;
    end

    // The final byte of a file forces a result if none was given yet.
    if (feed.last_byte && !emit && phase != PH_DONE) begin
      emit        = 1'b1;
      emit_status = tste_pkg::ST_EARLY;
    end

    if (emit) begin
      phase_next = PH_DONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_HEADER;
      byte_position    <= '0;
      directory_offset <= '0;
      entries_left     <= '0;
      entry_byte_index <= '0;
      offset_seen      <= '0;
      length_seen      <= '0;
      match_count      <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (take && feed.last_byte) begin
        // End of file: start over for the next one.
        phase            <= PH_HEADER;
        byte_position    <= '0;
        directory_offset <= '0;
        entries_left     <= '0;
        entry_byte_index <= '0;
        offset_seen      <= '0;
        length_seen      <= '0;
        match_count      <= '0;
      end else if (take) begin
        phase            <= phase_next;
        byte_position    <= byte_position_next;
        directory_offset <= directory_offset_next;
        entries_left     <= entries_left_next;
        entry_byte_index <= entry_byte_index_next;
        offset_seen      <= offset_seen_next;
        length_seen      <= length_seen_next;
        match_count      <= match_count_next;
      end
      if (take && emit) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
    // Payload registers need no reset.
    if (take && emit) begin
      out_status <= emit_status;
      out_offset <= (emit_status == tste_pkg::ST_OK) ? offset_seen_next : '0;
      out_length <= (emit_status == tste_pkg::ST_OK) ? length_seen_next : '0;
    end
    if (take && phase == PH_ENTRY) begin
      entry_bytes[entry_byte_index] <= b;
    end
  end

`ifndef ASSERT_OFF

  // Captured values only leave the block with an ok status.
  a_zero_payload_on_error: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_status != tste_pkg::ST_OK) |-> (out_offset == '0 && out_length == '0))
    else $error("strip fields nonzero on an error result");

  // The entry walk is only entered with at least one entry to read.
  a_entry_has_work: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_ENTRY) |-> (entries_left != '0))
    else $error("entry phase with no entries left");

  // The byte index never leaves the twelve-byte entry.
  a_index_in_range: assert property (@(posedge clk) disable iff (rst)
    entry_byte_index <= LastIdx)
    else $error("entry byte index out of range");

  // A final byte returns the parser to the start of a file.
  a_restart_after_last: assert property (@(posedge clk) disable iff (rst)
    (take && feed.last_byte) |=> (phase == PH_HEADER && byte_position == '0))
    else $error("parser did not restart after the final byte");

`endif

endmodule : tiff_strip_tag_extractor

`default_nettype wire
